FILE: rtl/core/dmsl_pkg.sv
package dmsl_pkg;

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PWM_MAX       = 3'd0,
      CSR_PWM_DEADBAND  = 3'd1,
      CSR_REVERSE_GUARD = 3'd2,
      CSR_ACCEL_RATE    = 3'd3,
      CSR_DECEL_RATE    = 3'd4
   } csr_index_type;

   localparam logic [7:0]  PWM_MAX_RESET       = 8'd255;
   localparam logic [7:0]  PWM_DEADBAND_RESET  = 8'd0;
   localparam logic [7:0]  REVERSE_GUARD_RESET = 8'd60;
   localparam logic [15:0] ACCEL_RATE_RESET    = 16'd500;
   localparam logic [15:0] DECEL_RATE_RESET    = 16'd800;

   // Any rate*dt product above this value rounds to a limit of 512 or
   // more, which saturates to 511 anyway.
   localparam logic [18:0] PROD_SAT      = 19'd511499;
   localparam logic [19:0] ROUND_HALF    = 20'd500;
   // x/1000 = (x/8)/125; the quotient by 125 is a multiply by
   // ceil(2^23/125), exact for dividends below 2^16.
   localparam logic [16:0] RECIP_125     = 17'd67109;
   localparam int          RECIP_SHIFT   = 23;
   localparam logic [8:0]  STEP_LIMIT_MIN = 9'd1;

   typedef struct packed {
      logic signed [8:0] target_left;
      logic signed [8:0] target_right;
      logic [31:0]       now_ms;
      logic              safe_stop;
   } stage1_type;

   typedef struct packed {
      logic signed [8:0] target_left;
      logic signed [8:0] target_right;
      logic              safe_stop;
      logic [18:0]       accel_prod;
      logic [18:0]       decel_prod;
   } stage2_type;

   typedef struct packed {
      logic signed [8:0] target_left;
      logic signed [8:0] target_right;
      logic              safe_stop;
      logic [8:0]        step_up;
      logic [8:0]        step_down;
   } stage3_type;

   typedef struct packed {
      logic [7:0] fwd;
      logic [7:0] rev;
   } bridge_type;

   // Rounded quotient by 1000 of a saturated product, kept within 1..511.
   function automatic logic [8:0] step_limit(input logic [18:0] prod);
      logic [19:0] rounded;
      logic [32:0] scaled;
      logic [8:0]  quot;
      rounded = {1'b0, prod} + ROUND_HALF;
      scaled  = 33'(rounded[18:3]) * 33'(RECIP_125);
      quot    = scaled[RECIP_SHIFT+8:RECIP_SHIFT];
      return (quot == 9'd0) ? STEP_LIMIT_MIN : quot;
   endfunction

   function automatic logic [8:0] magnitude(input logic signed [8:0] value);
      return value[8] ? 9'(-value) : 9'(value);
   endfunction

   // A reversal from a level above the guard is forced through zero first.
   function automatic logic signed [8:0] guard_target(
      input logic signed [8:0] level,
      input logic signed [8:0] target,
      input logic [7:0]        guard
   );
      if (target == 9'sd0) begin
         return 9'sd0;
      end else if (level == 9'sd0) begin
         return target;
      end else if ((level[8] != target[8]) && (magnitude(level) > {1'b0, guard})) begin
         return 9'sd0;
      end else begin
         return target;
      end
   endfunction

   function automatic logic signed [8:0] ramp_to(
      input logic signed [8:0] prev,
      input logic signed [8:0] target,
      input logic [8:0]        step_up,
      input logic [8:0]        step_down
   );
      logic signed [10:0] prev_w;
      logic signed [10:0] target_w;
      logic signed [10:0] next_w;
      prev_w   = 11'(prev);
      target_w = 11'(target);
      if (target_w > prev_w) begin
         next_w = prev_w + $signed({2'b00, step_up});
         return (next_w < target_w) ? next_w[8:0] : target;
      end else begin
         next_w = prev_w - $signed({2'b00, step_down});
         return (next_w > target_w) ? next_w[8:0] : target;
      end
   endfunction

   function automatic bridge_type drive(
      input logic signed [8:0] level,
      input logic [7:0]        pwm_max,
      input logic [7:0]        deadband
   );
      logic [8:0] duty;
      bridge_type result;
      duty = magnitude(level);
      if (duty > {1'b0, pwm_max}) begin
         duty = {1'b0, pwm_max};
      end
      result = '0;
      if (duty >= {1'b0, deadband}) begin
         if (level > 9'sd0) begin
            result.fwd = duty[7:0];
         end else begin
            result.rev = duty[7:0];
         end
      end
      return result;
   endfunction

endpackage

FILE: rtl/core/dual_motor_slew_limiter_top.sv
// A request beat runs through stages one to three and the output register onto rsp_tvalid.
// Throughput: one beat per cycle unless the output stalls; the ramp levels close their loop in
// the last stage alone. A stage holds a beat the next cannot take; stalls squeeze out bubbles.
// Reset (synchronous, active high) empties the pipeline, zeroes both ramps and the step time,
// and loads the configuration registers with their documented defaults.
module dual_motor_slew_limiter_top
   import dmsl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   // Configuration write port.
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,

   // Request stream.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // From bit 0: target_left[8:0], target_right[8:0], now_ms[31:0], zero padding.
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // Bit 0: safe_stop.
   input  logic                   req_tuser,

   // Response stream.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // From bit 0: left_fwd_pwm[7:0], left_rev_pwm[7:0], right_fwd_pwm[7:0],
   // right_rev_pwm[7:0], level_left[8:0], level_right[8:0], zero padding.
   output logic [RSP_DATA_W-1:0]  rsp_tdata
);

   // Configuration registers.
   logic [7:0]  pwm_max_ff;
   logic [7:0]  pwm_deadband_ff;
   logic [7:0]  reverse_guard_ff;
   logic [15:0] accel_rate_ff;
   logic [15:0] decel_rate_ff;

   // Controller state. The step time is updated as a beat leaves stage one; the ramps
   // are updated as a beat leaves stage three, so every beat sees its predecessor's state.
   logic [31:0]       last_step_ms_ff;
   logic [31:0]       last_step_ms_in;
   logic signed [8:0] ramp_left_ff;
   logic signed [8:0] ramp_right_ff;
   logic signed [8:0] ramp_left_in;
   logic signed [8:0] ramp_right_in;

   // Pipeline registers and their valid flags.
   stage1_type s1_ff;
   stage1_type s1_in;
   stage2_type s2_ff;
   stage2_type s2_in;
   stage3_type s3_ff;
   stage3_type s3_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic s3_valid_ff;
   logic rsp_valid_ff;

   // A stage can take a beat when it is empty or its beat moves on in the same cycle.
   logic out_ready;
   logic s3_ready;
   logic s2_ready;
   logic s1_ready;

   assign out_ready = !rsp_valid_ff || rsp_tready;
   assign s3_ready  = !s3_valid_ff || out_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;

   assign req_tready = s1_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Configuration writes; indexes beyond the register list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_max_ff       <= PWM_MAX_RESET;
         pwm_deadband_ff  <= PWM_DEADBAND_RESET;
         reverse_guard_ff <= REVERSE_GUARD_RESET;
         accel_rate_ff    <= ACCEL_RATE_RESET;
         decel_rate_ff    <= DECEL_RATE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PWM_MAX:       pwm_max_ff       <= csr_wdata[7:0];
            CSR_PWM_DEADBAND:  pwm_deadband_ff  <= csr_wdata[7:0];
            CSR_REVERSE_GUARD: reverse_guard_ff <= csr_wdata[7:0];
            CSR_ACCEL_RATE:    accel_rate_ff    <= csr_wdata;
            CSR_DECEL_RATE:    decel_rate_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage one captures the request beat as it arrives.
   always_comb begin
      s1_in.target_left  = $signed(req_tdata[8:0]);
      s1_in.target_right = $signed(req_tdata[17:9]);
      s1_in.now_ms       = req_tdata[49:18];
      s1_in.safe_stop    = req_tuser;
   end

   // Stage two: elapsed time and the rate products. A stored step time of zero means
   // there was no step yet, so the elapsed time counts as zero. Every beat, safe stop
   // included, records its own time as the new step time. Products are saturated
   // where the step limit would saturate, so only 19 bits travel on.
   logic [31:0] elapsed_ms;
   logic [47:0] accel_full;
   logic [47:0] decel_full;

   always_comb begin
      elapsed_ms = (last_step_ms_ff == 32'd0) ? 32'd0 : s1_ff.now_ms - last_step_ms_ff;
      accel_full = 48'(accel_rate_ff) * 48'(elapsed_ms);
      decel_full = 48'(decel_rate_ff) * 48'(elapsed_ms);

      s2_in.target_left  = s1_ff.target_left;
      s2_in.target_right = s1_ff.target_right;
      s2_in.safe_stop    = s1_ff.safe_stop;
      s2_in.accel_prod   = (accel_full > 48'(PROD_SAT)) ? PROD_SAT : accel_full[18:0];
      s2_in.decel_prod   = (decel_full > 48'(PROD_SAT)) ? PROD_SAT : decel_full[18:0];

      last_step_ms_in = (s1_valid_ff && s2_ready) ? s1_ff.now_ms : last_step_ms_ff;
   end

   // Stage three: rounded division by 1000 into step limits of 1 to 511.
   always_comb begin
      s3_in.target_left  = s2_ff.target_left;
      s3_in.target_right = s2_ff.target_right;
      s3_in.safe_stop    = s2_ff.safe_stop;
      s3_in.step_up      = step_limit(s2_ff.accel_prod);
      s3_in.step_down    = step_limit(s2_ff.decel_prod);
   end

   // Output stage: reverse guard, ramp toward the guarded target and the bridge drive.
   // Safe stop zeroes both ramps and every output field.
   logic signed [8:0] guarded_left;
   logic signed [8:0] guarded_right;
   logic signed [8:0] level_left;
   logic signed [8:0] level_right;
   bridge_type        bridge_left;
   bridge_type        bridge_right;

   always_comb begin
      guarded_left  = guard_target(ramp_left_ff, s3_ff.target_left, reverse_guard_ff);
      guarded_right = guard_target(ramp_right_ff, s3_ff.target_right, reverse_guard_ff);

      if (s3_ff.safe_stop) begin
         level_left  = 9'sd0;
         level_right = 9'sd0;
      end else begin
         level_left  = ramp_to(ramp_left_ff, guarded_left, s3_ff.step_up, s3_ff.step_down);
         level_right = ramp_to(ramp_right_ff, guarded_right, s3_ff.step_up, s3_ff.step_down);
      end

      bridge_left  = drive(level_left, pwm_max_ff, pwm_deadband_ff);
      bridge_right = drive(level_right, pwm_max_ff, pwm_deadband_ff);

      rsp_data_in = {6'd0, level_right, level_left, bridge_right.rev, bridge_right.fwd,
                     bridge_left.rev, bridge_left.fwd};

      if (s3_valid_ff && out_ready) begin
         ramp_left_in  = level_left;
         ramp_right_in = level_right;
      end else begin
         ramp_left_in  = ramp_left_ff;
         ramp_right_in = ramp_right_ff;
      end
   end

   // Control state and valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         s3_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         last_step_ms_ff <= 32'd0;
         ramp_left_ff    <= 9'sd0;
         ramp_right_ff   <= 9'sd0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (out_ready) begin
            rsp_valid_ff <= s3_valid_ff;
         end
         last_step_ms_ff <= last_step_ms_in;
         ramp_left_ff    <= ramp_left_in;
         ramp_right_ff   <= ramp_right_in;
      end
   end

   // Payload registers load whenever their stage may take a beat.
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_ff <= s1_in;
      end
      if (s2_ready) begin
         s2_ff <= s2_in;
      end
      if (s3_ready) begin
         s3_ff <= s3_in;
      end
      if (out_ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
